### rtl/tbfe_pkg.sv
// Shared types, codes and microcode program of the three-band equalizer.
`timescale 1ns / 1ps
package tbfe_pkg;

    // Payload types
    typedef logic signed [15:0] sample_t;
    typedef logic signed [15:0] coef_t;
    typedef logic        [15:0] gain_t;
    typedef logic        [1:0]  band_t;
    typedef logic        [8:0]  tap_num_t;
    typedef logic        [1:0]  reg_index_t;

    // Item opcodes
    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    // Band codes
    localparam band_t BAND_LOW  = 2'd0;
    localparam band_t BAND_MID  = 2'd1;
    localparam band_t BAND_HIGH = 2'd2;

    // Configuration register indexes
    localparam reg_index_t REG_GAIN_LOW  = 2'd0;
    localparam reg_index_t REG_GAIN_MID  = 2'd1;
    localparam reg_index_t REG_GAIN_HIGH = 2'd2;

    // Gain reset values (about 0.7, 0.6 and 0.5 in Q1.15)
    localparam gain_t GAIN_LOW_RESET  = 16'd22938;
    localparam gain_t GAIN_MID_RESET  = 16'd19661;
    localparam gain_t GAIN_HIGH_RESET = 16'd16384;

    // Output limits
    localparam sample_t SAMPLE_MAX = 16'sh7FFF;
    localparam sample_t SAMPLE_MIN = 16'sh8000;

    // Microcode step addresses
    typedef logic [2:0] step_t;
    localparam step_t STEP_IDLE   = 3'd0;
    localparam step_t STEP_MAC    = 3'd1;
    localparam step_t STEP_DRAIN0 = 3'd2;
    localparam step_t STEP_DRAIN1 = 3'd3;
    localparam step_t STEP_DRAIN2 = 3'd4;
    localparam step_t STEP_FINISH = 3'd5;
    localparam step_t STEP_RET    = 3'd6;

    // Jump conditions: a taken jump goes to the target, else to the next step
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_SAMPLE,
        COND_LOOP,
        COND_OUT_BUSY
    } cond_t;

    // One control word
    typedef struct packed {
        logic  wait_in;
        logic  issue;
        logic  finish;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    // Control store
    function automatic ctrl_word_t ucode(step_t step);
        ctrl_word_t w;
        w = '{wait_in: 1'b0, issue: 1'b0, finish: 1'b0, cond: COND_NEVER,
              target: STEP_IDLE};
        unique case (step)
            STEP_IDLE:
            begin
                w.wait_in = 1'b1;
                w.cond    = COND_NO_SAMPLE;
                w.target  = STEP_IDLE;
            end
            STEP_MAC:
            begin
                w.issue  = 1'b1;
                w.cond   = COND_LOOP;
                w.target = STEP_MAC;
            end
            STEP_DRAIN0, STEP_DRAIN1, STEP_DRAIN2:
            begin
                w.cond = COND_NEVER;
            end
            STEP_FINISH:
            begin
                w.finish = 1'b1;
                w.cond   = COND_OUT_BUSY;
                w.target = STEP_FINISH;
            end
            STEP_RET:
            begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
            default:
            begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

### rtl/tbfe_in_if.sv
// Input channel: sample and coefficient-load items.
`timescale 1ns / 1ps
interface tbfe_in_if;
    import tbfe_pkg::*;

    logic     valid;
    logic     ready;
    logic     opcode;
    band_t    band_select;
    tap_num_t tap_number;
    coef_t    coefficient_value;
    sample_t  audio_in;

    modport source (
        output valid, opcode, band_select, tap_number, coefficient_value, audio_in,
        input  ready
    );
    modport sink (
        input  valid, opcode, band_select, tap_number, coefficient_value, audio_in,
        output ready
    );
endinterface

### rtl/tbfe_out_if.sv
// Output channel: equalized samples.
`timescale 1ns / 1ps
interface tbfe_out_if;
    import tbfe_pkg::*;

    logic    valid;
    logic    ready;
    sample_t audio_out;
    logic    clipped;

    modport source (
        output valid, audio_out, clipped,
        input  ready
    );
    modport sink (
        input  valid, audio_out, clipped,
        output ready
    );
endinterface

### rtl/three_band_fir_equalizer.sv
// Three-band FIR equalizer: microcoded MAC sequencer, delay and coefficient memories.
//
// Usage:
//   in_ch carries items: opcode OP_LOAD writes coefficient_value into band
//   band_select at tap_number (ignored for band code 3 or tap at or beyond TAPS);
//   opcode OP_FILTER pushes audio_in into the delay line and yields one result.
//   out_ch carries audio_out (saturated to 16 bits) and clipped.
//   cfg_we/cfg_index/cfg_data write the three band gains; write only when idle.
// Timing:
//   A load item is taken in the idle step. A sample item runs one
//   multiply-accumulate per cycle over the three bands through a single MAC
//   pipeline, set by the one read port per memory, then the drain, finish and
//   return steps; the finish step writes the result to the output register.
// Reset:
//   Gains return to their defaults and the delay line reads as all zeros at
//   once (a fill count masks old entries, so there is no clearing pass).
//   Coefficients are undefined until loaded.
// Stall:
//   A finished result waits in the output register; the next item is taken
//   meanwhile, and a later result holds in the finish step until it drains.
`timescale 1ns / 1ps
module three_band_fir_equalizer #(
    parameter int TAPS = 320
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  tbfe_pkg::reg_index_t   cfg_index,
    input  tbfe_pkg::gain_t        cfg_data,
    tbfe_in_if.sink                in_ch,
    tbfe_out_if.source             out_ch
);
    import tbfe_pkg::*;

    localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CW    = $clog2(TAPS + 1);
    localparam int PW    = 32;
    localparam int QW    = 49;
    localparam int ACC_W = QW + 1 + $clog2(3 * TAPS);
    localparam int YW    = ACC_W - 30;

    localparam logic [AW-1:0] TAP_LAST  = AW'(TAPS - 1);
    localparam logic [CW-1:0] FILL_FULL = CW'(TAPS);
    localparam logic [10:0]   TAPS_EXT  = 11'(TAPS);
    localparam logic signed [YW-1:0] Y_MAX = YW'(32767);
    localparam logic signed [YW-1:0] Y_MIN = -(YW'(32768));

    // Gain registers
    gain_t gain_low_reg, gain_mid_reg, gain_high_reg;

    // Memories
    sample_t delay_mem [TAPS];
    coef_t   low_mem   [TAPS];
    coef_t   mid_mem   [TAPS];
    coef_t   high_mem  [TAPS];

    // Sequencer and loop state
    step_t      step_reg, step_next;
    ctrl_word_t ctrl;
    logic       jump;
    logic [AW-1:0] tap_cnt_reg, tap_cnt_next;
    band_t         band_cnt_reg, band_cnt_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0] head_reg;
    logic [CW-1:0] fill_reg;

    // MAC pipeline
    logic           s1_valid_reg, s2_valid_reg, s3_valid_reg;
    band_t          s1_band_reg, s2_band_reg;
    logic           s1_tap_ok_reg;
    sample_t        s1_sample_reg;
    coef_t          s1_low_reg, s1_mid_reg, s1_high_reg;
    logic signed [PW-1:0]    p_reg;
    logic signed [QW-1:0]    q_reg;
    logic signed [ACC_W-1:0] acc_reg;

    // Output register
    logic    out_valid_reg;
    sample_t audio_out_reg;
    logic    clipped_reg;

    logic in_xfer, sample_xfer, load_xfer, out_busy, fin_fire, loop_more, tap_end;
    coef_t   coef_sel;
    sample_t sample_sel;
    gain_t   gain_sel;
    logic signed [YW-1:0] y_trunc;
    sample_t y_sat;
    logic    y_clip;

    // Decode handshakes and control word
    assign ctrl        = ucode(step_reg);
    assign in_ch.ready = ctrl.wait_in;
    assign in_xfer     = in_ch.valid && ctrl.wait_in;
    assign sample_xfer = in_xfer && (in_ch.opcode == OP_FILTER);
    assign load_xfer   = in_xfer && (in_ch.opcode == OP_LOAD)
                         && ({2'b00, in_ch.tap_number} < TAPS_EXT);
    assign out_busy    = out_valid_reg && !out_ch.ready;
    assign fin_fire    = ctrl.finish && !out_busy;
    assign tap_end     = (tap_cnt_reg == TAP_LAST);
    assign loop_more   = !(tap_end && (band_cnt_reg == BAND_HIGH));

    // Select jump condition
    always_comb
    begin
        case (ctrl.cond)
            COND_ALWAYS:    jump = 1'b1;
            COND_NO_SAMPLE: jump = !sample_xfer;
            COND_LOOP:      jump = loop_more;
            COND_OUT_BUSY:  jump = out_busy;
            default:        jump = 1'b0;
        endcase
        step_next = jump ? ctrl.target : step_reg + 3'd1;
    end

    // Advance tap, band and delay read pointer
    always_comb
    begin
        tap_cnt_next  = tap_cnt_reg;
        band_cnt_next = band_cnt_reg;
        rd_ptr_next   = rd_ptr_reg;
        if (sample_xfer)
        begin
            tap_cnt_next  = '0;
            band_cnt_next = BAND_LOW;
            rd_ptr_next   = head_reg;
        end
        else if (ctrl.issue)
        begin
            if (tap_end)
            begin
                tap_cnt_next  = '0;
                band_cnt_next = band_cnt_reg + 2'd1;
                rd_ptr_next   = head_reg;
            end
            else
            begin
                tap_cnt_next = tap_cnt_reg + AW'(1);
                rd_ptr_next  = (rd_ptr_reg == '0) ? TAP_LAST : rd_ptr_reg - AW'(1);
            end
        end
    end

    // Hold sequencer and loop registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= STEP_IDLE;
            tap_cnt_reg  <= '0;
            band_cnt_reg <= BAND_LOW;
            rd_ptr_reg   <= '0;
            head_reg     <= '0;
            fill_reg     <= '0;
        end
        else
        begin
            step_reg     <= step_next;
            tap_cnt_reg  <= tap_cnt_next;
            band_cnt_reg <= band_cnt_next;
            rd_ptr_reg   <= rd_ptr_next;
            if (sample_xfer && (fill_reg != FILL_FULL))
                fill_reg <= fill_reg + CW'(1);
            if (fin_fire)
                head_reg <= (head_reg == TAP_LAST) ? '0 : head_reg + AW'(1);
        end
    end

    // Write gain registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_low_reg  <= GAIN_LOW_RESET;
            gain_mid_reg  <= GAIN_MID_RESET;
            gain_high_reg <= GAIN_HIGH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAIN_LOW:  gain_low_reg  <= cfg_data;
                REG_GAIN_MID:  gain_mid_reg  <= cfg_data;
                REG_GAIN_HIGH: gain_high_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Write new sample and read delay line
    always_ff @(posedge clk)
    begin
        if (sample_xfer)
            delay_mem[head_reg] <= in_ch.audio_in;
        s1_sample_reg <= delay_mem[rd_ptr_reg];
    end

    // Load coefficients and read all three bands at the current tap
    always_ff @(posedge clk)
    begin
        if (load_xfer && (in_ch.band_select == BAND_LOW))
            low_mem[AW'(in_ch.tap_number)] <= in_ch.coefficient_value;
        s1_low_reg <= low_mem[tap_cnt_reg];
    end

    always_ff @(posedge clk)
    begin
        if (load_xfer && (in_ch.band_select == BAND_MID))
            mid_mem[AW'(in_ch.tap_number)] <= in_ch.coefficient_value;
        s1_mid_reg <= mid_mem[tap_cnt_reg];
    end

    always_ff @(posedge clk)
    begin
        if (load_xfer && (in_ch.band_select == BAND_HIGH))
            high_mem[AW'(in_ch.tap_number)] <= in_ch.coefficient_value;
        s1_high_reg <= high_mem[tap_cnt_reg];
    end

    // Pick band operands
    always_comb
    begin
        case (s1_band_reg)
            BAND_LOW: coef_sel = s1_low_reg;
            BAND_MID: coef_sel = s1_mid_reg;
            default:  coef_sel = s1_high_reg;
        endcase
        case (s2_band_reg)
            BAND_LOW: gain_sel = gain_low_reg;
            BAND_MID: gain_sel = gain_mid_reg;
            default:  gain_sel = gain_high_reg;
        endcase
        sample_sel = s1_tap_ok_reg ? s1_sample_reg : '0;
    end

    // Advance MAC pipeline valid and band tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s1_band_reg   <= BAND_LOW;
            s2_band_reg   <= BAND_LOW;
            s1_tap_ok_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= ctrl.issue;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s1_band_reg   <= band_cnt_reg;
            s2_band_reg   <= s1_band_reg;
            s1_tap_ok_reg <= (CW'(tap_cnt_reg) < fill_reg);
        end
    end

    // Multiply coefficient by sample, then by band gain
    always_ff @(posedge clk)
    begin
        p_reg <= coef_sel * sample_sel;
        q_reg <= p_reg * $signed({1'b0, gain_sel});
    end

    // Clear on a new sample, then accumulate weighted products
    always_ff @(posedge clk)
    begin
        if (sample_xfer)
            acc_reg <= '0;
        else if (s3_valid_reg)
            acc_reg <= acc_reg + ACC_W'(q_reg);
    end

    // Truncate toward zero and saturate
    always_comb
    begin
        y_trunc = $signed(acc_reg[ACC_W-1:30]);
        if (acc_reg[ACC_W-1] && (acc_reg[29:0] != '0))
            y_trunc = y_trunc + YW'(1);
        if (y_trunc > Y_MAX)
        begin
            y_sat  = SAMPLE_MAX;
            y_clip = 1'b1;
        end
        else if (y_trunc < Y_MIN)
        begin
            y_sat  = SAMPLE_MIN;
            y_clip = 1'b1;
        end
        else
        begin
            y_sat  = y_trunc[15:0];
            y_clip = 1'b0;
        end
    end

    // Hold result until transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fin_fire)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fin_fire)
        begin
            audio_out_reg <= y_sat;
            clipped_reg   <= y_clip;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.audio_out = audio_out_reg;
    assign out_ch.clipped   = clipped_reg;

endmodule
